// ----- sv/dpfa_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the demand page frame allocator
package dpfa_pkg;

    localparam int unsigned ADDR_W     = 15;
    localparam int unsigned PID_W      = 5;
    localparam int unsigned GROUP_SIZE = 16;
    localparam int unsigned GROUP_W    = 4;

    localparam logic        CMD_ACCESS    = 1'b0;
    localparam logic        CMD_TERMINATE = 1'b1;

    localparam logic [23:0] COST_HIT_WRITE = 24'd5000005;
    localparam logic [23:0] COST_HIT_READ  = 24'd5000010;
    localparam logic [23:0] COST_FAULT     = 24'd14001053;
    localparam logic [23:0] COST_NONE      = 24'd0;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_MOD,
        ST_LOOK,
        ST_CHECK,
        ST_SRCH_GRP,
        ST_SRCH_FRM,
        ST_RESP,
        ST_TERM_RD,
        ST_TERM_FREE
    } state_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_HIT,
        RES_FAULT_MAP,
        RES_FAULT_FULL
    } res_kind_t;

    typedef enum logic {
        RD_LOOKUP,
        RD_WALK
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_CLEAR,
        WR_WALK,
        WR_MAP
    } wr_sel_t;

    typedef struct packed {
        logic      capture;
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      wr_en;
        wr_sel_t   wr_sel;
        logic      cnt_rst;
        logic      cnt_inc;
        logic      fault_inc;
        logic      grp_latch;
        logic      frame_alloc;
        logic      frame_free;
        logic      set_res;
        res_kind_t res_kind;
        logic      push;
    } dp_cmd_t;

    typedef struct packed {
        logic proc_ok;
        logic term;
        logic hit;
        logic grp_found;
        logic clr_last;
        logic walk_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- sv/dpfa_if.sv -----
`timescale 1ns / 1ps
// request and response channel interfaces of the frame allocator
interface dpfa_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [4:0]  process_id;
    logic [14:0] address;
    logic        write_access;

    modport source (output valid, output command, output process_id, output address,
                    output write_access, input ready);
    modport sink   (input valid, input command, input process_id, input address,
                    input write_access, output ready);
endinterface

interface dpfa_rsp_if;
    logic        valid;
    logic        ready;
    logic        page_fault;
    logic        granted;
    logic [7:0]  frame_number;
    logic [23:0] cost_ns;
    logic [31:0] fault_total;

    modport source (output valid, output page_fault, output granted, output frame_number,
                    output cost_ns, output fault_total, input ready);
    modport sink   (input valid, input page_fault, input granted, input frame_number,
                    input cost_ns, input fault_total, output ready);
endinterface

// ----- sv/dpfa_ctrl.sv -----
`timescale 1ns / 1ps
// sequencing state machine of the frame allocator
module dpfa_ctrl
    import dpfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_CLEAR;
                if (stat.clr_last)
                begin
                    cmd.cnt_rst = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!stat.proc_ok)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RES_ZERO;
                    state_next   = ST_RESP;
                end
                else if (stat.term)
                begin
                    cmd.cnt_rst = 1'b1;
                    state_next  = ST_TERM_RD;
                end
                else
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_LOOKUP;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.hit)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RES_HIT;
                    state_next   = ST_RESP;
                end
                else
                begin
                    cmd.fault_inc = 1'b1;
                    state_next    = ST_SRCH_GRP;
                end
            end
            ST_SRCH_GRP:
            begin
                cmd.grp_latch = 1'b1;
                state_next    = ST_SRCH_FRM;
            end
            ST_SRCH_FRM:
            begin
                cmd.set_res = 1'b1;
                if (stat.grp_found)
                begin
                    cmd.frame_alloc = 1'b1;
                    cmd.wr_en       = 1'b1;
                    cmd.wr_sel      = WR_MAP;
                    cmd.res_kind    = RES_FAULT_MAP;
                end
                else
                begin
                    cmd.res_kind = RES_FAULT_FULL;
                end
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_TERM_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_WALK;
                state_next = ST_TERM_FREE;
            end
            ST_TERM_FREE:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_WALK;
                if (stat.hit)
                begin
                    cmd.frame_free = 1'b1;
                end
                if (stat.walk_last)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RES_ZERO;
                    state_next   = ST_RESP;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_TERM_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/dpfa_datapath.sv -----
`timescale 1ns / 1ps
// page map memory, frame usage bits, free frame search, fault counter and result register
module dpfa_datapath
    import dpfa_pkg::*;
#(
    parameter int unsigned NUM_PROCS      = 18,
    parameter int unsigned PAGES_PER_PROC = 32,
    parameter int unsigned NUM_FRAMES     = 256,
    parameter int unsigned PAGE_BYTES     = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    input  logic              in_command,
    input  logic [PID_W-1:0]  in_process_id,
    input  logic [ADDR_W-1:0] in_address,
    input  logic              in_write_access,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              out_page_fault,
    output logic              out_granted,
    output logic [7:0]        out_frame_number,
    output logic [23:0]       out_cost_ns,
    output logic [31:0]       out_fault_total
);

    localparam int unsigned MAP_DEPTH = NUM_PROCS * PAGES_PER_PROC;
    localparam int unsigned AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int unsigned FW        = $clog2(NUM_FRAMES);
    localparam int unsigned PGW       = (PAGES_PER_PROC > 1) ? $clog2(PAGES_PER_PROC) : 1;
    localparam int unsigned NGRP      = (NUM_FRAMES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int unsigned GRW       = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int unsigned MW        = ADDR_W + 2;
    localparam int unsigned PW        = ADDR_W + MW;
    localparam int unsigned BW        = PID_W + 7;
    localparam int unsigned TW        = ADDR_W + 7;

    // reciprocal constants for address / PAGE_BYTES and quotient % PAGES_PER_PROC
    localparam int unsigned L1 = $clog2(PAGE_BYTES);
    localparam int unsigned S1 = ADDR_W + L1;
    localparam longint unsigned M1 = ((64'd1 << S1) + PAGE_BYTES - 1) / PAGE_BYTES;
    localparam int unsigned L2 = $clog2(PAGES_PER_PROC);
    localparam int unsigned S2 = ADDR_W + L2;
    localparam longint unsigned M2 = ((64'd1 << S2) + PAGES_PER_PROC - 1) / PAGES_PER_PROC;
    localparam logic [MW-1:0] M1_C = MW'(M1);
    localparam logic [MW-1:0] M2_C = MW'(M2);

    logic              term_reg;
    logic              proc_ok_reg;
    logic              wr_acc_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [AW-1:0]     base_reg;
    logic [BW-1:0]     base_full;

    logic [PW-1:0]     prod1_reg;
    logic [PW-1:0]     prod2_reg;
    logic [ADDR_W-1:0] quot;
    logic [ADDR_W-1:0] quot_reg;
    logic [ADDR_W-1:0] mod_t;
    logic [TW-1:0]     mod_tp;
    logic [PGW-1:0]    page;
    logic [AW-1:0]     lookup_idx;
    logic [AW-1:0]     walk_idx;
    logic [AW-1:0]     cnt_reg;

    logic [FW:0]       map_mem [MAP_DEPTH];
    logic [FW:0]       rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [FW:0]       wr_data;

    logic [NUM_FRAMES-1:0]        used_reg;
    logic [NGRP*GROUP_SIZE-1:0]   free_pad;
    logic [NGRP-1:0]              grp_free;
    logic [GRW-1:0]               grp_sel;
    logic [GRW-1:0]               grp_reg;
    logic                         grp_found_reg;
    logic [GROUP_SIZE-1:0]        grp_word;
    logic [GROUP_W-1:0]           low_sel;
    logic [GRW+GROUP_W-1:0]       frame_wide;
    logic [FW-1:0]                frame_sel;
    logic [FW+7:0]                hit_frame_ext;
    logic [FW+7:0]                alloc_frame_ext;

    logic [31:0]       fault_reg;
    logic              res_fault_reg;
    logic              res_grant_reg;
    logic [7:0]        res_frame_reg;
    logic [23:0]       res_cost_reg;
    logic              out_valid_reg;

    // captured transaction
    assign base_full = BW'(in_process_id) * BW'(PAGES_PER_PROC);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            term_reg    <= (in_command == CMD_TERMINATE);
            proc_ok_reg <= (32'(in_process_id) < NUM_PROCS);
            wr_acc_reg  <= in_write_access;
            addr_reg    <= in_address;
            base_reg    <= AW'(base_full);
        end
    end

    // page number through two reciprocal multiplies
    assign quot = ADDR_W'(prod1_reg >> S1);

    always_ff @(posedge clk)
    begin
        prod1_reg <= PW'(addr_reg) * PW'(M1_C);
        quot_reg  <= quot;
        prod2_reg <= PW'(quot) * PW'(M2_C);
    end

    assign mod_t      = ADDR_W'(prod2_reg >> S2);
    assign mod_tp     = TW'(mod_t) * TW'(PAGES_PER_PROC);
    assign page       = PGW'(quot_reg - mod_tp[ADDR_W-1:0]);
    assign lookup_idx = base_reg + AW'(page);
    assign walk_idx   = base_reg + cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_rst)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // page map memory
    assign rd_addr = (cmd.rd_sel == RD_WALK) ? walk_idx : lookup_idx;

    always_comb
    begin
        case (cmd.wr_sel)
            WR_CLEAR:
            begin
                wr_addr = cnt_reg;
                wr_data = '0;
            end
            WR_WALK:
            begin
                wr_addr = walk_idx;
                wr_data = '0;
            end
            WR_MAP:
            begin
                wr_addr = lookup_idx;
                wr_data = {1'b1, frame_sel};
            end
            default:
            begin
                wr_addr = lookup_idx;
                wr_data = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    // free frame search: group summary, then frame within group
    for (genvar i = 0; i < NGRP * GROUP_SIZE; i++)
    begin : g_free
        if (i < NUM_FRAMES)
        begin : g_real
            assign free_pad[i] = ~used_reg[i];
        end
        else
        begin : g_pad
            assign free_pad[i] = 1'b0;
        end
    end

    for (genvar g = 0; g < NGRP; g++)
    begin : g_grp
        assign grp_free[g] = |free_pad[g*GROUP_SIZE +: GROUP_SIZE];
    end

    always_comb
    begin
        grp_sel = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_free[g])
            begin
                grp_sel = GRW'(g);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.grp_latch)
        begin
            grp_reg       <= grp_sel;
            grp_found_reg <= |grp_free;
        end
    end

    assign grp_word = free_pad[grp_reg*GROUP_SIZE +: GROUP_SIZE];

    always_comb
    begin
        low_sel = '0;
        for (int b = GROUP_SIZE - 1; b >= 0; b--)
        begin
            if (grp_word[b])
            begin
                low_sel = GROUP_W'(b);
            end
        end
    end

    assign frame_wide = {grp_reg, low_sel};
    assign frame_sel  = FW'(frame_wide);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.frame_alloc)
        begin
            used_reg[frame_sel] <= 1'b1;
        end
        else if (cmd.frame_free)
        begin
            used_reg[rd_data_reg[FW-1:0]] <= 1'b0;
        end
    end

    // saturating fault counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_reg <= '0;
        end
        else if (cmd.fault_inc && (fault_reg != 32'hFFFF_FFFF))
        begin
            fault_reg <= fault_reg + 32'd1;
        end
    end

    // result assembly
    assign hit_frame_ext   = {8'b0, rd_data_reg[FW-1:0]};
    assign alloc_frame_ext = {8'b0, frame_sel};

    always_ff @(posedge clk)
    begin
        if (cmd.set_res)
        begin
            case (cmd.res_kind)
                RES_HIT:
                begin
                    res_fault_reg <= 1'b0;
                    res_grant_reg <= 1'b1;
                    res_frame_reg <= hit_frame_ext[7:0];
                    res_cost_reg  <= wr_acc_reg ? COST_HIT_WRITE : COST_HIT_READ;
                end
                RES_FAULT_MAP:
                begin
                    res_fault_reg <= 1'b1;
                    res_grant_reg <= 1'b1;
                    res_frame_reg <= alloc_frame_ext[7:0];
                    res_cost_reg  <= COST_FAULT;
                end
                RES_FAULT_FULL:
                begin
                    res_fault_reg <= 1'b1;
                    res_grant_reg <= 1'b0;
                    res_frame_reg <= '0;
                    res_cost_reg  <= COST_FAULT;
                end
                default:
                begin
                    res_fault_reg <= 1'b0;
                    res_grant_reg <= 1'b0;
                    res_frame_reg <= '0;
                    res_cost_reg  <= COST_NONE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_page_fault   <= res_fault_reg;
            out_granted      <= res_grant_reg;
            out_frame_number <= res_frame_reg;
            out_cost_ns      <= res_cost_reg;
            out_fault_total  <= fault_reg;
        end
    end

    assign out_valid = out_valid_reg;

    assign stat.proc_ok   = proc_ok_reg;
    assign stat.term      = term_reg;
    assign stat.hit       = rd_data_reg[FW];
    assign stat.grp_found = grp_found_reg;
    assign stat.clr_last  = (cnt_reg == AW'(MAP_DEPTH - 1));
    assign stat.walk_last = (cnt_reg == AW'(PAGES_PER_PROC - 1));
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

// ----- sv/demand_page_frame_allocator.sv -----
`timescale 1ns / 1ps
// Demand paging page table with a lowest-free-first frame allocator.
// req carries one transaction: command (access or terminate), process_id,
// address and write_access; rsp returns page_fault, granted, frame_number,
// cost_ns and the running fault_total, one response per request.
// One request is in flight at a time; req.ready is high only while idle.
// Access hit: acceptance, reciprocal divide of the address, page map read and
// result register before rsp.valid. Access miss: as a hit, adding the
// two-level free frame search (group summary, then frame within the group).
// Terminate: walks the process's page map entries through the single page
// map read port, reading and then freeing each entry.
// A new request is taken in the cycle after the response is loaded, even if
// the previous response still waits in the output register.
// After reset the page map memory is cleared one entry a cycle, all
// NUM_PROCS*PAGES_PER_PROC entries (576 by default), before req.ready rises.
// When rsp.ready is low and the output register is full, the response is held
// and the block stalls in its response state until the output register frees up.
module demand_page_frame_allocator
    import dpfa_pkg::*;
#(
    parameter int unsigned NUM_PROCS      = 18,
    parameter int unsigned PAGES_PER_PROC = 32,
    parameter int unsigned NUM_FRAMES     = 256,
    parameter int unsigned PAGE_BYTES     = 1024
)
(
    input logic        clk,
    input logic        rst_n,
    dpfa_req_if.sink   req,
    dpfa_rsp_if.source rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_ready;

    assign req.ready = in_ready;

    dpfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dpfa_datapath #(
        .NUM_PROCS      (NUM_PROCS),
        .PAGES_PER_PROC (PAGES_PER_PROC),
        .NUM_FRAMES     (NUM_FRAMES),
        .PAGE_BYTES     (PAGE_BYTES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .in_command       (req.command),
        .in_process_id    (req.process_id),
        .in_address       (req.address),
        .in_write_access  (req.write_access),
        .out_ready        (rsp.ready),
        .out_valid        (rsp.valid),
        .out_page_fault   (rsp.page_fault),
        .out_granted      (rsp.granted),
        .out_frame_number (rsp.frame_number),
        .out_cost_ns      (rsp.cost_ns),
        .out_fault_total  (rsp.fault_total)
    );

endmodule

// ----- sv/dpfa_checker.sv -----
`timescale 1ns / 1ps
// port-level checker of the frame allocator and its bind
module dpfa_checker
    import dpfa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        page_fault,
    input logic        granted,
    input logic [7:0]  frame_number,
    input logic [23:0] cost_ns
);

    // held response stays
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // one transaction in flight
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken back to back");

    a_fault_cost: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && page_fault |-> cost_ns == COST_FAULT)
        else $error("fault with wrong cost");

    a_hit_cost: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && granted && !page_fault |->
            (cost_ns == COST_HIT_WRITE) || (cost_ns == COST_HIT_READ))
        else $error("hit with wrong cost");

    a_no_grant_frame: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !granted |-> frame_number == 8'd0)
        else $error("frame reported without grant");

endmodule

bind demand_page_frame_allocator dpfa_checker u_dpfa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .page_fault   (rsp.page_fault),
    .granted      (rsp.granted),
    .frame_number (rsp.frame_number),
    .cost_ns      (rsp.cost_ns)
);
